// ===== design/ovl_pkg.sv =====
// shared types and constants for the ordered value list table
// no dependencies; imported by the controller, the datapath and the top level
package ovl_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = 5;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_REMOVE = 3'd1,
      MODE_QUERY  = 3'd2,
      MODE_READ   = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_POSITION = 2'd2
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // carry out the request and load the response register
   } ctl_cmd_type;

endpackage

// ===== design/ordered_value_list_table_top.sv =====
// Ordered value list table, top level.
// One request word on req_ yields exactly one response word on rsp_.
// A request appends a value, removes the first equal entry (later entries
// close up), asks whether a value is present, reads the entry at a 1-based
// position, or clears the list. Every response carries the count after it.
// Sequence: a request is taken into the request registers in the idle state,
// carried out in the execute state, which loads the response register; no
// new request is taken until then, set by the accept/execute sequence of the
// controller over the single bank of entry registers.
// Stalls: while rsp_tready is low the response holds, one more request may
// be taken and waits in the execute state until the response register frees.
// Reset: synchronous, active high; the list becomes empty, no response is
// pending. Entry contents are not cleared, only the count.
// Depends on ovl_pkg, ovl_ctrl and ovl_dpath.
module ordered_value_list_table_top
   import ovl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // mode[2:0], value[34:3], position[39:35]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // found[0], read_value[32:1], count[37:33],
                                              // status[39:38]
);

   ctl_cmd_type cmd;

   ovl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ovl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[37:33] <= CNT_W'(LIST_DEPTH)))
      else $error("response count beyond list depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39:38] == STATUS_FULL) |->
      (rsp_tdata[37:33] == CNT_W'(LIST_DEPTH)))
      else $error("full status with list not full");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");

   a_found_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[32:1] == '0 &&
      rsp_tdata[39:38] == STATUS_OK))
      else $error("match flag together with read data or error status");

endmodule

// ===== design/ovl_ctrl.sv =====
// controller for the ordered value list table: request sequencing and response valid
// depends on ovl_pkg
module ovl_ctrl
   import ovl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_tvalid) state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            if (out_free) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         CTL_EXEC: begin
            cmd.exec = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // a new response replaces one that leaves in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/ovl_dpath.sv =====
// datapath for the ordered value list table: entry registers, count, compare and close-up
// depends on ovl_pkg
module ovl_dpath
   import ovl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [2:0]       mode_ff;
   logic [VAL_W-1:0] value_ff;
   logic [POS_W-1:0] position_ff;

   logic [VAL_W-1:0] entries_ff [LIST_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [LIST_DEPTH-1:0] match;
   logic [LIST_DEPTH-1:0] at_or_after;
   logic                  any_match;
   logic                  is_full;
   logic                  pos_bad;
   logic [POS_W-1:0]      pos_m1;
   logic [CNT_W-1:0]      count_next;
   logic                  found_in;
   logic [VAL_W-1:0]      read_in;
   status_type            status_in;

   logic                  found_ff;
   logic [VAL_W-1:0]      read_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   status_type            status_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= req_tdata[2:0];
         value_ff    <= req_tdata[34:3];
         position_ff <= req_tdata[39:35];
      end
   end

   always_comb begin
      for (int k = 0; k < LIST_DEPTH; k++)
         match[k] = (entries_ff[k] == value_ff) && (CNT_W'(k) < count_ff);
   end

   // bits at and above the first match
   assign at_or_after = match | (~match + LIST_DEPTH'(1));
   assign any_match   = |match;
   assign is_full     = (count_ff == CNT_W'(LIST_DEPTH));
   assign pos_m1      = position_ff - POS_W'(1);
   assign pos_bad     = (position_ff == '0) || (position_ff > POS_W'(count_ff));

   always_comb begin
      count_next = count_ff;
      found_in   = 1'b0;
      read_in    = '0;
      status_in  = STATUS_OK;
      unique case (mode_ff)
         MODE_APPEND: begin
            if (is_full) status_in = STATUS_FULL;
            else count_next = count_ff + CNT_W'(1);
         end
         MODE_REMOVE: begin
            found_in = any_match;
            if (any_match) count_next = count_ff - CNT_W'(1);
         end
         MODE_QUERY: begin
            found_in = any_match;
         end
         MODE_READ: begin
            if (pos_bad) status_in = STATUS_POSITION;
            else read_in = entries_ff[pos_m1[IDX_W-1:0]];
         end
         MODE_CLEAR: begin
            count_next = '0;
         end
         default: begin
            count_next = count_ff;
         end
      endcase
   end

   assign count_in = cmd.exec ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (mode_ff == MODE_APPEND && !is_full)
            entries_ff[count_ff[IDX_W-1:0]] <= value_ff;
         if (mode_ff == MODE_REMOVE && any_match) begin
            for (int k = 0; k < LIST_DEPTH - 1; k++)
               if (at_or_after[k]) entries_ff[k] <= entries_ff[k+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         found_ff     <= found_in;
         read_ff      <= read_in;
         rsp_count_ff <= count_next;
         status_ff    <= status_in;
      end
   end

   assign rsp_tdata = {status_ff, rsp_count_ff, read_ff, found_ff};

endmodule

// ===== tb/sv/ovl_list_checker.sv =====
`timescale 1ns / 100ps
// response checker for the ordered value list table: keeps a shadow copy of the list,
// predicts one response word per accepted request word and compares it in order
// depends on ovl_pkg for widths, mode and status codes
module ovl_list_checker
   import ovl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // mode[2:0], value[34:3], position[39:35]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // found[0], read_value[32:1], count[37:33],
                                              // status[39:38]
   output int                    fail_count,
   output int                    pending,
   output int                    answers_checked,
   output int                    full_drops,
   output int                    range_errors,
   output int                    match_hits
);

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic [CNT_W-1:0] count;
      status_type       status;
   } list_answer_t;

   logic [VAL_W-1:0] shadow_entries [LIST_DEPTH];
   int               shadow_count;
   list_answer_t     list_answers_q [$];

   // carries out one request on the shadow list and returns the response it gives
   function automatic list_answer_t apply_list_request(input logic [REQ_DATA_W-1:0] word);
      logic [2:0]       mode;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] pos;
      list_answer_t     ans;
      int               at;
      mode  = word[2:0];
      value = word[34:3];
      pos   = word[39:35];
      ans   = '0;
      at    = -1;
      for (int k = 0; k < shadow_count; k++) begin
         if (at < 0 && shadow_entries[k] == value) at = k;
      end
      case (mode)
         MODE_APPEND: begin
            if (shadow_count >= LIST_DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            if (at >= 0) begin
               ans.found = 1'b1;
               // later entries close up by one place
               for (int k = at; k + 1 < shadow_count; k++)
                  shadow_entries[k] = shadow_entries[k + 1];
               shadow_count--;
            end
         end
         MODE_QUERY: begin
            ans.found = (at >= 0);
         end
         MODE_READ: begin
            if (pos == 0 || pos > shadow_count)
               ans.status = STATUS_POSITION;
            else
               ans.read_value = shadow_entries[pos - 1];
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      ans.count = shadow_count[CNT_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin
      list_answer_t want;
      if (reset) begin
         list_answers_q.delete();
         shadow_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (list_answers_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response word %h with no request waiting", $realtime,
                           rsp_tdata);
            end else begin
               want = list_answers_q.pop_front();
               answers_checked++;
               if (want.status == STATUS_FULL) full_drops++;
               if (want.status == STATUS_POSITION) range_errors++;
               if (want.found) match_hits++;
               if (rsp_tdata[0] !== want.found || rsp_tdata[32:1] !== want.read_value ||
                   rsp_tdata[37:33] !== want.count || rsp_tdata[39:38] !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: response %0d mismatch (expected/actual): found %0b/%0b",
                            $realtime, answers_checked, want.found, rsp_tdata[0]);
                     $display(" read_value %h/%h count %0d/%0d status %0d/%0d",
                              want.read_value, rsp_tdata[32:1], want.count,
                              rsp_tdata[37:33], want.status, rsp_tdata[39:38]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            list_answers_q.push_back(apply_list_request(req_tdata));
      end
      pending <= list_answers_q.size();
   end

endmodule

// ===== tb/sv/tb_ordered_value_list_table_top.sv =====
`timescale 1ns / 100ps
// top of the ordered value list table testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict
// depends on ovl_pkg, ordered_value_list_table_top and ovl_list_checker
module tb_ordered_value_list_table_top;
   import ovl_pkg::*;

   localparam int RANDOM_ITEMS   = 1600;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_OFF_LONG  = 150;

   typedef enum int {
      RX_READY,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE,
      RX_HOLD
   } rx_pattern_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int answers_checked;
   int full_drops;
   int range_errors;
   int match_hits;

   int               items_sent;
   int               directed_items;
   int               burst_left;
   logic [VAL_W-1:0] value_pool [8];

   always #10 clock = ~clock;

   ordered_value_list_table_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ovl_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .answers_checked (answers_checked),
      .full_drops      (full_drops),
      .range_errors    (range_errors),
      .match_hits      (match_hits)
   );

   // offers one request word and returns at the edge that accepts it
   task automatic send_word(input logic [2:0] mode, input logic [VAL_W-1:0] value,
                            input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [VAL_W-1:0] fresh_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // mostly values that may already sit in the list, so removes and queries hit
   function automatic logic [VAL_W-1:0] pool_value();
      if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   function automatic logic [POS_W-1:0] random_pos();
      if ($urandom_range(0, 6) != 0) return POS_W'($urandom_range(0, LIST_DEPTH + 1));
      return POS_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [2:0] mixed_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 36) return MODE_APPEND;
      if (r < 56) return MODE_REMOVE;
      if (r < 74) return MODE_QUERY;
      if (r < 94) return MODE_READ;
      if (r < 97) return MODE_CLEAR;
      return 3'($urandom_range(int'(MODE_CLEAR) + 1, 7));
   endfunction

   task automatic run_directed();
      // empty list: read, remove and query find nothing
      send_word(MODE_READ,   32'h0000_0000, 5'd0);
      send_word(MODE_READ,   32'h0000_0000, 5'd1);
      send_word(MODE_REMOVE, 32'h0000_0005, 5'd0);
      send_word(MODE_QUERY,  32'h0000_0005, 5'd0);
      send_word(MODE_APPEND, 32'h8000_0000, 5'd0);
      send_word(MODE_APPEND, 32'h7FFF_FFFF, 5'd31);
      send_word(MODE_APPEND, 32'h0000_0000, 5'd0);
      send_word(MODE_APPEND, 32'hFFFF_FFFF, 5'd0);
      send_word(MODE_QUERY,  32'h7FFF_FFFF, 5'd0);
      send_word(MODE_QUERY,  32'h0000_007B, 5'd0);
      send_word(MODE_READ,   32'h0000_0000, 5'd1);
      send_word(MODE_READ,   32'h0000_0000, 5'd4);
      send_word(MODE_READ,   32'h0000_0000, 5'd5);
      send_word(MODE_READ,   32'hFFFF_FFFF, 5'd31);
      // remove from the middle, then read across the gap
      send_word(MODE_REMOVE, 32'h7FFF_FFFF, 5'd0);
      send_word(MODE_READ,   32'h0000_0000, 5'd2);
      for (int m = int'(MODE_CLEAR) + 1; m < 8; m++)
         send_word(3'(m), 32'hA5A5_5A5A, 5'd31);
      send_word(MODE_CLEAR,  32'hFFFF_FFFF, 5'd31);
      // the sole entry removed leaves an empty list
      send_word(MODE_APPEND, 32'h0000_002A, 5'd0);
      send_word(MODE_REMOVE, 32'h0000_002A, 5'd0);
      send_word(MODE_QUERY,  32'h0000_002A, 5'd0);
   endtask

   task automatic run_random();
      int goal;
      int pick;
      int n;
      goal = items_sent + RANDOM_ITEMS;
      for (int k = 0; k < 8; k++) value_pool[k] = fresh_value();
      while (items_sent < goal) begin
         if ($urandom_range(0, 2) == 0) value_pool[$urandom_range(0, 7)] = fresh_value();
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            // fill run, often past full
            n = $urandom_range(8, 20);
            repeat (n) send_word(MODE_APPEND, pool_value(), random_pos());
         end else if (pick == 2) begin
            n = $urandom_range(3, 12);
            repeat (n) send_word(MODE_REMOVE, pool_value(), random_pos());
         end else if (pick == 3) begin
            send_word(MODE_CLEAR, $urandom(), random_pos());
            n = $urandom_range(1, 8);
            repeat (n) send_word(MODE_APPEND, pool_value(), random_pos());
         end else begin
            n = $urandom_range(5, 25);
            repeat (n) send_word(mixed_mode(), pool_value(), random_pos());
         end
      end
   endtask

   // receiver back-pressure, one long hold-off early on and more at random
   initial begin : receiver
      rx_pattern_t pattern;
      int          span;
      int          period;
      int          phase_no;
      phase_no = 0;
      @(posedge clock);
      forever begin
         period = $urandom_range(2, 5);
         if (phase_no == 2) begin
            pattern = RX_HOLD;
            span    = HOLD_OFF_LONG;
         end else if ($urandom_range(0, 11) == 0) begin
            pattern = RX_HOLD;
            span    = $urandom_range(40, HOLD_OFF_LONG);
         end else begin
            pattern = rx_pattern_t'($urandom_range(int'(RX_READY), int'(RX_SPARSE)));
            span    = $urandom_range(10, 120);
         end
         for (int n = 0; n < span; n++) begin
            case (pattern)
               RX_READY:    rsp_tready <= 1'b1;
               RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_tready <= (n % period) != 0;
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= 1'b0;
            endcase
            @(posedge clock);
         end
         phase_no++;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("timeout: no word moved for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, pending);
      $display("tb_ordered_value_list_table_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      items_sent = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      directed_items = items_sent;
      run_random();
      req_tvalid <= 1'b0;
      // let the checker count the last accepted word before draining
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d requests (%0d directed), %0d responses checked",
               items_sent, directed_items, answers_checked);
      $display("list full on %0d appends, %0d reads out of range, %0d remove/query matches",
               full_drops, range_errors, match_hits);
      if (fail_count == 0)
         $display("tb_ordered_value_list_table_top: PASS");
      else
         $display("tb_ordered_value_list_table_top: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/ovl_pkg.sv
design/ovl_ctrl.sv
design/ovl_dpath.sv
design/ordered_value_list_table_top.sv
tb/sv/ovl_list_checker.sv
tb/sv/tb_ordered_value_list_table_top.sv
